[hw/rtl/rsc_pkg.sv]
// ---------------------------------------------------------------------------
// rsc_pkg - shared constants and helpers for the RGB/spherical converter
// Fixed-point constants, CORDIC angle table, status codes and stage map.
// ---------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

	// data format: signed Q16.16
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	// CORDIC iterations and digit-by-digit root steps
	localparam int STEPS      = 32;
	localparam int ROOT_STEPS = DATA_W;

	// rounding shifts of the scaled products
	localparam int ANG_SHIFT = 33 + FRAC_W;   // radians to binary angle
	localparam int RAD_SHIFT = 91 - FRAC_W;   // binary angle to radians
	localparam int MUL_SHIFT = 60;            // Q60 sine/cosine products

	localparam logic [61:0]        PI_Q60    = 62'h3243F6A8885A308D;
	localparam logic [63:0]        INVPI_Q64 = 64'h517CC1B727220A95;
	localparam logic signed [63:0] KINV_Q60  = 64'sh09B74EDA80000000;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// pipeline stage map
	localparam int S_SQ    = 0;                    // squares, angle partials
	localparam int S_SUM   = 1;                    // sums, angle rounding
	localparam int S_FOLD  = 2;                    // angle sign and fold
	localparam int S_ROOT0 = 3;                    // first root step
	localparam int S_NORM  = S_ROOT0 + ROOT_STEPS; // leading one search
	localparam int S_INIT  = S_NORM + 1;           // normalize, CORDIC load
	localparam int S_CRD0  = S_INIT + 1;           // first CORDIC step
	localparam int S_MUL1  = S_CRD0 + STEPS;       // first products
	localparam int S_ADD1  = S_MUL1 + 1;
	localparam int S_MUL2  = S_ADD1 + 1;           // second products
	localparam int S_ADD2  = S_MUL2 + 1;
	localparam int S_OUT   = S_ADD2 + 1;           // clamp and status
	localparam int NUM_ST  = S_OUT + 1;

	// atan(2^-k) as a 32-bit binary angle
	function automatic logic [31:0] atan_bam(input logic [4:0] k);
		logic [31:0] a;
		case (k)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rgb_spherical_converter.sv]
// ---------------------------------------------------------------------------
// rgb_spherical_converter - pixel conversion RGB <-> hue/saturation/intensity
// Mode 0: (r,g,b) -> (atan2(r,b), atan2(sqrt(r^2+b^2),g), sqrt(r^2+g^2+b^2)).
// Mode 1: (h,s,i) -> (|i sin s| sin h sgn(cos h), i cos s, |i sin s||cos h|).
// ---------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   mode, operand_x, operand_y, operand_z
//  out      out  out_valid/out_stall result_x, result_y, result_z, status
//
// One word per clock, while no output word is held, through 74 register
// stages. The length is set by the 32 root steps and the 32 CORDIC steps,
// one per stage, plus the product and rounding stages. Reset clears only
// the stage valid bits.
// A stall on a valid output word freezes every stage; the input is stalled with it.
`default_nettype none

module rgb_spherical_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [31:0] operand_x,
	input  wire logic [31:0] operand_y,
	input  wire logic [31:0] operand_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_x,
	output logic [31:0]      result_y,
	output logic [31:0]      result_z,
	output logic [1:0]       status
);

	localparam int NST = rsc_pkg::NUM_ST;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic               zero_px;
		logic [63:0]        sq_r;
		logic [63:0]        sq_g;
		logic [63:0]        sq_b;
		logic [63:0]        apl0;
		logic [63:0]        aph0;
		logic [63:0]        apl1;
		logic [63:0]        aph1;
		logic [63:0]        rb;
		logic [63:0]        rall;
		logic [31:0]        bq0;
		logic [31:0]        bq1;
		logic [35:0]        rem_a;
		logic [35:0]        rem_b;
		logic [31:0]        root_a;
		logic [31:0]        root_b;
		logic [31:0]        ux0;
		logic [31:0]        uy0;
		logic [31:0]        ux1;
		logic [31:0]        uy1;
		logic [5:0]         sh0;
		logic [5:0]         sh1;
		logic               nz0;
		logic               nz1;
		logic               flip0;
		logic               flip1;
		logic signed [63:0] cx0;
		logic signed [63:0] cy0;
		logic signed [63:0] cx1;
		logic signed [63:0] cy1;
		logic signed [33:0] cz0;
		logic signed [33:0] cz1;
		logic [66:0]        pl0;
		logic [66:0]        ph0;
		logic [66:0]        pl1;
		logic [66:0]        ph1;
		logic               neg0;
		logic               neg1;
		logic [61:0]        chm;
		logic [61:0]        shm;
		logic               chneg;
		logic               shneg;
		logic [34:0]        mq;
		logic signed [35:0] rx;
		logic signed [35:0] ry;
		logic signed [35:0] rz;
		logic [1:0]         st;
	} item_t;

	item_t            item_in;
	item_t            nxt    [NST];
	item_t            item_s [NST];
	logic [NST-1:0]   vld_s;
	logic             en;

	// whole pipe advances unless the output word is held
	assign en        = !(vld_s[NST-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[NST-1];
	assign result_x  = item_s[NST-1].rx[31:0];
	assign result_y  = item_s[NST-1].ry[31:0];
	assign result_z  = item_s[NST-1].rz[31:0];
	assign status    = item_s[NST-1].st;

	always_comb begin
		item_in      = '0;
		item_in.mode = mode;
		item_in.ox   = operand_x;
		item_in.oy   = operand_y;
		item_in.oz   = operand_z;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			item_s <= nxt;
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		if (i == rsc_pkg::S_SQ) begin : g_sq
			logic [31:0] mr, mg, mb;
			// magnitudes, squares and partials of angle scaling
			always_comb begin
				nxt[i]         = item_in;
				mr             = rsc_pkg::mag32(item_in.ox);
				mg             = rsc_pkg::mag32(item_in.oy);
				mb             = rsc_pkg::mag32(item_in.oz);
				nxt[i].zero_px = (item_in.ox == '0) && (item_in.oy == '0) &&
				                 (item_in.oz == '0);
				nxt[i].sq_r    = 64'(mr) * 64'(mr);
				nxt[i].sq_g    = 64'(mg) * 64'(mg);
				nxt[i].sq_b    = 64'(mb) * 64'(mb);
				nxt[i].apl0    = 64'(mg) * 64'(rsc_pkg::INVPI_Q64[31:0]);
				nxt[i].aph0    = 64'(mg) * 64'(rsc_pkg::INVPI_Q64[63:32]);
				nxt[i].apl1    = 64'(mr) * 64'(rsc_pkg::INVPI_Q64[31:0]);
				nxt[i].aph1    = 64'(mr) * 64'(rsc_pkg::INVPI_Q64[63:32]);
			end
		end else if (i == rsc_pkg::S_SUM) begin : g_sum
			logic [95:0] p0, p1;
			// sums of squares; rounded binary angle magnitudes
			always_comb begin
				nxt[i]      = item_s[i-1];
				nxt[i].rb   = item_s[i-1].sq_r + item_s[i-1].sq_b;
				nxt[i].rall = item_s[i-1].sq_r + item_s[i-1].sq_b + item_s[i-1].sq_g;
				p0 = 96'(item_s[i-1].apl0) + (96'(item_s[i-1].aph0) << 32) +
				     (96'(1) << (rsc_pkg::ANG_SHIFT - 1));
				p1 = 96'(item_s[i-1].apl1) + (96'(item_s[i-1].aph1) << 32) +
				     (96'(1) << (rsc_pkg::ANG_SHIFT - 1));
				nxt[i].bq0 = p0[rsc_pkg::ANG_SHIFT+31:rsc_pkg::ANG_SHIFT];
				nxt[i].bq1 = p1[rsc_pkg::ANG_SHIFT+31:rsc_pkg::ANG_SHIFT];
			end
		end else if (i == rsc_pkg::S_FOLD) begin : g_fold
			logic [31:0] b0, b1, t0, t1, z0, z1;
			// sign the angle, fold it into [-pi/2, pi/2)
			always_comb begin
				nxt[i]       = item_s[i-1];
				b0           = item_s[i-1].oy[31] ? 32'(-item_s[i-1].bq0) : item_s[i-1].bq0;
				b1           = item_s[i-1].ox[31] ? 32'(-item_s[i-1].bq1) : item_s[i-1].bq1;
				t0           = b0 + 32'h4000_0000;
				t1           = b1 + 32'h4000_0000;
				z0           = t0[31] ? b0 + 32'h8000_0000 : b0;
				z1           = t1[31] ? b1 + 32'h8000_0000 : b1;
				nxt[i].flip0 = t0[31];
				nxt[i].flip1 = t1[31];
				nxt[i].cz0   = {{2{z0[31]}}, z0};
				nxt[i].cz1   = {{2{z1[31]}}, z1};
			end
		end else if (i >= rsc_pkg::S_ROOT0 && i < rsc_pkg::S_NORM) begin : g_root
			localparam int K = rsc_pkg::S_NORM - 1 - i;
			logic [35:0] rpa, rpb, tta, ttb;
			logic        gea, geb;
			// one result bit per stage for both roots
			always_comb begin
				nxt[i]        = item_s[i-1];
				rpa           = {item_s[i-1].rem_a[33:0], item_s[i-1].rb[2*K+1:2*K]};
				rpb           = {item_s[i-1].rem_b[33:0], item_s[i-1].rall[2*K+1:2*K]};
				tta           = {2'b00, item_s[i-1].root_a, 2'b01};
				ttb           = {2'b00, item_s[i-1].root_b, 2'b01};
				gea           = rpa >= tta;
				geb           = rpb >= ttb;
				nxt[i].rem_a  = gea ? rpa - tta : rpa;
				nxt[i].rem_b  = geb ? rpb - ttb : rpb;
				nxt[i].root_a = {item_s[i-1].root_a[30:0], gea};
				nxt[i].root_b = {item_s[i-1].root_b[30:0], geb};
			end
		end else if (i == rsc_pkg::S_NORM) begin : g_norm
			logic [31:0] o0, o1;
			logic [4:0]  p0, p1;
			// leading one of each vector, for a common normalizing shift
			always_comb begin
				nxt[i]     = item_s[i-1];
				nxt[i].ux0 = rsc_pkg::mag32(item_s[i-1].oz);
				nxt[i].uy0 = rsc_pkg::mag32(item_s[i-1].ox);
				nxt[i].ux1 = rsc_pkg::mag32(item_s[i-1].oy);
				nxt[i].uy1 = item_s[i-1].root_a;
				o0         = nxt[i].ux0 | nxt[i].uy0;
				o1         = nxt[i].ux1 | nxt[i].uy1;
				p0         = '0;
				p1         = '0;
				for (int j = 0; j < 32; j++) begin
					if (o0[j]) p0 = 5'(j);
					if (o1[j]) p1 = 5'(j);
				end
				nxt[i].nz0 = |o0;
				nxt[i].nz1 = |o1;
				nxt[i].sh0 = 6'd59 - {1'b0, p0};
				nxt[i].sh1 = 6'd59 - {1'b0, p1};
			end
		end else if (i == rsc_pkg::S_INIT) begin : g_init
			logic [63:0] u0, u1;
			// load CORDIC: normalized vectors or the gain-scaled unit vector
			always_comb begin
				nxt[i] = item_s[i-1];
				u0     = 64'(item_s[i-1].uy0) << item_s[i-1].sh0;
				u1     = 64'(item_s[i-1].uy1) << item_s[i-1].sh1;
				if (item_s[i-1].mode) begin
					nxt[i].cx0 = rsc_pkg::KINV_Q60;
					nxt[i].cx1 = rsc_pkg::KINV_Q60;
					nxt[i].cy0 = '0;
					nxt[i].cy1 = '0;
				end else begin
					nxt[i].cx0 = signed'(64'(item_s[i-1].ux0) << item_s[i-1].sh0);
					nxt[i].cx1 = signed'(64'(item_s[i-1].ux1) << item_s[i-1].sh1);
					nxt[i].cy0 = (item_s[i-1].ox[31] ^ item_s[i-1].oz[31]) ?
					             signed'(64'(-u0)) : signed'(u0);
					nxt[i].cy1 = item_s[i-1].oy[31] ? signed'(64'(-u1)) : signed'(u1);
					nxt[i].cz0 = item_s[i-1].oz[31] ? 34'sh0_8000_0000 : '0;
					nxt[i].cz1 = item_s[i-1].oy[31] ? 34'sh0_8000_0000 : '0;
				end
			end
		end else if (i >= rsc_pkg::S_CRD0 && i < rsc_pkg::S_MUL1) begin : g_crd
			localparam int K = i - rsc_pkg::S_CRD0;
			logic signed [33:0] ang;
			logic               up0, up1;
			// one micro-rotation per lane: rotate on z, or vector on y
			always_comb begin
				nxt[i] = item_s[i-1];
				ang    = signed'({2'b00, rsc_pkg::atan_bam(5'(K))});
				up0    = item_s[i-1].mode ? !item_s[i-1].cz0[33] : item_s[i-1].cy0[63];
				up1    = item_s[i-1].mode ? !item_s[i-1].cz1[33] : item_s[i-1].cy1[63];
				if (up0) begin
					nxt[i].cx0 = item_s[i-1].cx0 - (item_s[i-1].cy0 >>> K);
					nxt[i].cy0 = item_s[i-1].cy0 + (item_s[i-1].cx0 >>> K);
					nxt[i].cz0 = item_s[i-1].cz0 - ang;
				end else begin
					nxt[i].cx0 = item_s[i-1].cx0 + (item_s[i-1].cy0 >>> K);
					nxt[i].cy0 = item_s[i-1].cy0 - (item_s[i-1].cx0 >>> K);
					nxt[i].cz0 = item_s[i-1].cz0 + ang;
				end
				if (up1) begin
					nxt[i].cx1 = item_s[i-1].cx1 - (item_s[i-1].cy1 >>> K);
					nxt[i].cy1 = item_s[i-1].cy1 + (item_s[i-1].cx1 >>> K);
					nxt[i].cz1 = item_s[i-1].cz1 - ang;
				end else begin
					nxt[i].cx1 = item_s[i-1].cx1 + (item_s[i-1].cy1 >>> K);
					nxt[i].cy1 = item_s[i-1].cy1 - (item_s[i-1].cx1 >>> K);
					nxt[i].cz1 = item_s[i-1].cz1 + ang;
				end
			end
		end else if (i == rsc_pkg::S_MUL1) begin : g_mul1
			logic [31:0] bm0, bm1;
			logic [32:0] m0, m1;
			logic [34:0] a0, a1;
			logic [61:0] b0, b1;
			logic        csneg;
			// first products: angle to radians, or intensity times cos/sin s
			always_comb begin
				nxt[i] = item_s[i-1];
				bm0    = item_s[i-1].nz0 ? item_s[i-1].cz0[31:0] : '0;
				bm1    = item_s[i-1].nz1 ? item_s[i-1].cz1[31:0] : '0;
				m0     = (bm0 > 32'h8000_0000) ? 33'h1_0000_0000 - 33'(bm0) : 33'(bm0);
				m1     = (bm1 > 32'h8000_0000) ? 33'h1_0000_0000 - 33'(bm1) : 33'(bm1);
				csneg  = (item_s[i-1].cx0 != '0) && (item_s[i-1].flip0 ^ item_s[i-1].cx0[63]);
				nxt[i].chm   = 62'(rsc_pkg::mag64(item_s[i-1].cx1));
				nxt[i].shm   = 62'(rsc_pkg::mag64(item_s[i-1].cy1));
				nxt[i].chneg = (item_s[i-1].cx1 != '0) &&
				               (item_s[i-1].flip1 ^ item_s[i-1].cx1[63]);
				nxt[i].shneg = (item_s[i-1].cy1 != '0) &&
				               (item_s[i-1].flip1 ^ item_s[i-1].cy1[63]);
				if (item_s[i-1].mode) begin
					a0          = 35'(rsc_pkg::mag32(item_s[i-1].oz));
					a1          = a0;
					b0          = 62'(rsc_pkg::mag64(item_s[i-1].cx0));
					b1          = 62'(rsc_pkg::mag64(item_s[i-1].cy0));
					nxt[i].neg0 = item_s[i-1].oz[31] ^ csneg;
					nxt[i].neg1 = 1'b0;
				end else begin
					a0          = 35'(m0);
					a1          = 35'(m1);
					b0          = rsc_pkg::PI_Q60;
					b1          = rsc_pkg::PI_Q60;
					nxt[i].neg0 = bm0 > 32'h8000_0000;
					nxt[i].neg1 = bm1 > 32'h8000_0000;
				end
				nxt[i].pl0 = 67'(a0) * 67'(b0[31:0]);
				nxt[i].ph0 = 67'(a0) * 67'(b0[61:32]);
				nxt[i].pl1 = 67'(a1) * 67'(b1[31:0]);
				nxt[i].ph1 = 67'(a1) * 67'(b1[61:32]);
			end
		end else if (i == rsc_pkg::S_ADD1) begin : g_add1
			logic [97:0]        p0, p1, rnd;
			logic [34:0]        q0, q1;
			logic signed [35:0] s0, s1;
			// add partials, round, scale
			always_comb begin
				nxt[i] = item_s[i-1];
				rnd    = item_s[i-1].mode ? (98'(1) << (rsc_pkg::MUL_SHIFT - 1)) :
				                            (98'(1) << (rsc_pkg::RAD_SHIFT - 1));
				p0     = 98'(item_s[i-1].pl0) + (98'(item_s[i-1].ph0) << 32) + rnd;
				p1     = 98'(item_s[i-1].pl1) + (98'(item_s[i-1].ph1) << 32) + rnd;
				q0     = item_s[i-1].mode ? 35'(p0 >> rsc_pkg::MUL_SHIFT) :
				                            35'(p0 >> rsc_pkg::RAD_SHIFT);
				q1     = item_s[i-1].mode ? 35'(p1 >> rsc_pkg::MUL_SHIFT) :
				                            35'(p1 >> rsc_pkg::RAD_SHIFT);
				s0     = signed'({1'b0, q0});
				s1     = signed'({1'b0, q1});
				nxt[i].mq = q1;
				nxt[i].ry = item_s[i-1].neg0 ? -s0 : s0;
				if (item_s[i-1].mode) begin
					nxt[i].rx = '0;
					nxt[i].rz = '0;
				end else begin
					nxt[i].ry = item_s[i-1].neg1 ? -s1 : s1;
					nxt[i].rx = item_s[i-1].neg0 ? -s0 : s0;
					nxt[i].rz = signed'(36'(item_s[i-1].root_b));
				end
			end
		end else if (i == rsc_pkg::S_MUL2) begin : g_mul2
			// second products: |i sin s| times |cos h| and |sin h|
			always_comb begin
				nxt[i]     = item_s[i-1];
				nxt[i].pl0 = 67'(item_s[i-1].mq) * 67'(item_s[i-1].chm[31:0]);
				nxt[i].ph0 = 67'(item_s[i-1].mq) * 67'(item_s[i-1].chm[61:32]);
				nxt[i].pl1 = 67'(item_s[i-1].mq) * 67'(item_s[i-1].shm[31:0]);
				nxt[i].ph1 = 67'(item_s[i-1].mq) * 67'(item_s[i-1].shm[61:32]);
			end
		end else if (i == rsc_pkg::S_ADD2) begin : g_add2
			logic [97:0]        p0, p1;
			logic signed [35:0] s0, s1;
			// blue and red of mode 1
			always_comb begin
				nxt[i] = item_s[i-1];
				p0 = 98'(item_s[i-1].pl0) + (98'(item_s[i-1].ph0) << 32) +
				     (98'(1) << (rsc_pkg::MUL_SHIFT - 1));
				p1 = 98'(item_s[i-1].pl1) + (98'(item_s[i-1].ph1) << 32) +
				     (98'(1) << (rsc_pkg::MUL_SHIFT - 1));
				s0 = signed'({1'b0, 35'(p0 >> rsc_pkg::MUL_SHIFT)});
				s1 = signed'({1'b0, 35'(p1 >> rsc_pkg::MUL_SHIFT)});
				if (item_s[i-1].mode) begin
					nxt[i].rz = s0;
					nxt[i].rx = (item_s[i-1].shneg ^ item_s[i-1].chneg) ? -s1 : s1;
				end
			end
		end else begin : g_out
			logic sx, sy, sz;
			// saturate to Q16.16, zero pixel case, status
			always_comb begin
				nxt[i] = item_s[i-1];
				sx = (item_s[i-1].rx > 36'sh0_7FFF_FFFF) || (item_s[i-1].rx < -36'sh0_8000_0000);
				sy = (item_s[i-1].ry > 36'sh0_7FFF_FFFF) || (item_s[i-1].ry < -36'sh0_8000_0000);
				sz = (item_s[i-1].rz > 36'sh0_7FFF_FFFF) || (item_s[i-1].rz < -36'sh0_8000_0000);
				if (sx) nxt[i].rx = item_s[i-1].rx[35] ? -36'sh0_8000_0000 : 36'sh0_7FFF_FFFF;
				if (sy) nxt[i].ry = item_s[i-1].ry[35] ? -36'sh0_8000_0000 : 36'sh0_7FFF_FFFF;
				if (sz) nxt[i].rz = item_s[i-1].rz[35] ? -36'sh0_8000_0000 : 36'sh0_7FFF_FFFF;
				nxt[i].st = (sx || sy || sz) ? rsc_pkg::ST_SAT : rsc_pkg::ST_OK;
				if (!item_s[i-1].mode && item_s[i-1].zero_px) begin
					nxt[i].rx = '0;
					nxt[i].ry = '0;
					nxt[i].rz = '0;
					nxt[i].st = rsc_pkg::ST_ZERO;
				end
			end
		end
	end

endmodule

`default_nettype wire
